// ----- src/e2c_pkg.sv -----
// Shared types, constants and tables of the equirectangular to cubemap remap unit.
package e2c_pkg;

  localparam int unsigned MaxFaceSize = 2048;
  localparam int unsigned AngleBits   = 20;
  localparam int unsigned Iters       = AngleBits;
  // Vector datapath width: doubled components (14 bits signed) at 2^16 scale plus CORDIC growth.
  localparam int unsigned VecW        = 34;
  localparam int unsigned HsqW        = 64;

  localparam logic [2:0] FaceYp = 3'd0;
  localparam logic [2:0] FaceXp = 3'd1;
  localparam logic [2:0] FaceYm = 3'd2;
  localparam logic [2:0] FaceXm = 3'd3;
  localparam logic [2:0] FaceZm = 3'd4;
  localparam logic [2:0] FaceZp = 3'd5;

  localparam logic [1:0] CfgFaceSize  = 2'd0;
  localparam logic [1:0] CfgPanoWidth = 2'd1;
  localparam logic [1:0] CfgPanoHeight = 2'd2;

  // Fields that ride along the pipeline with each pixel.
  typedef struct packed {
    logic        outside;
    logic [2:0]  face;
    logic [10:0] face_x;
    logic [10:0] face_y;
    logic        lon_zero;
    logic signed [13:0] z;
  } side_t;

  // One CORDIC lane: residual vector and accumulated angle in 2^-32 turn.
  typedef struct packed {
    logic signed [VecW-1:0] x;
    logic signed [VecW-1:0] y;
    logic [31:0]            acc;
  } cordic_t;

  // Arctangent table in units of 2^-32 turn.
  function automatic logic [31:0] atan_turn(input logic [4:0] k);
    logic [31:0] v;
    unique case (k)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      5'd24: v = 32'd41;
      5'd25: v = 32'd20;
      5'd26: v = 32'd10;
      5'd27: v = 32'd5;
      5'd28: v = 32'd3;
      5'd29: v = 32'd1;
      5'd30: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  // One vectoring micro-rotation; arithmetic shift is a floor shift.
  function automatic cordic_t cordic_iter(input cordic_t a, input logic [4:0] k);
    cordic_t r;
    logic signed [VecW-1:0] dx;
    logic signed [VecW-1:0] dy;
    dx = a.y >>> k;
    dy = a.x >>> k;
    if (!a.y[VecW-1]) begin
      r.x = a.x + dx;
      r.y = a.y - dy;
      r.acc = a.acc + atan_turn(k);
    end else begin
      r.x = a.x - dx;
      r.y = a.y + dy;
      r.acc = a.acc - atan_turn(k);
    end
    return r;
  endfunction

  // Pre-rotation: fold the left half plane over by a half turn.
  function automatic cordic_t cordic_init(input logic signed [VecW-1:0] x,
                                          input logic signed [VecW-1:0] y);
    cordic_t r;
    if (x[VecW-1]) begin
      r.x = -x;
      r.y = -y;
      r.acc = 32'h8000_0000;
    end else begin
      r.x = x;
      r.y = y;
      r.acc = 32'd0;
    end
    return r;
  endfunction

endpackage

// ----- src/e2c_cordic.sv -----
// Pipelined CORDIC vectoring angle unit, one micro-rotation per stage.
module e2c_cordic (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  input  logic signed [e2c_pkg::VecW-1:0] x_i,
  input  logic signed [e2c_pkg::VecW-1:0] y_i,
  output logic                           valid_o,
  output logic [31:0]                    angle_o
);

  e2c_pkg::cordic_t stage_q [e2c_pkg::Iters+1];
  logic [e2c_pkg::Iters:0] vld_q;

  // Stage zero folds the vector into the right half plane.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[e2c_pkg::Iters-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    stage_q[0] <= e2c_pkg::cordic_init(x_i, y_i);
  end

  // One rotation per register stage.
  for (genvar g = 0; g < e2c_pkg::Iters; g++) begin : g_it
    always_ff @(posedge clk_i) begin
      stage_q[g+1] <= e2c_pkg::cordic_iter(stage_q[g], 5'(g));
    end
  end

  assign valid_o = vld_q[e2c_pkg::Iters];
  assign angle_o = stage_q[e2c_pkg::Iters].acc;

endmodule

// ----- src/e2c_isqrt.sv -----
// Pipelined integer square root, one result bit per stage.
module e2c_isqrt (
  input  logic        clk_i,
  input  logic [63:0] n_i,
  output logic [31:0] root_o
);

  localparam int unsigned Steps = 32;

  logic [63:0] rem_q  [Steps+1];
  logic [31:0] root_q [Steps+1];

  always_ff @(posedge clk_i) begin
    rem_q[0]  <= n_i;
    root_q[0] <= '0;
  end

  // Restoring digit recurrence, most significant bit first.
  for (genvar g = 0; g < Steps; g++) begin : g_st
    logic [63:0] trial;
    logic [63:0] rem_d;
    logic [31:0] root_d;
    always_comb begin
      trial  = {root_q[g], 32'd0} >> g;
      trial  = trial | (64'd1 << (62 - 2 * g));
      root_d = root_q[g];
      rem_d  = rem_q[g];
      if (rem_q[g] >= trial) begin
        rem_d  = rem_q[g] - trial;
        root_d = root_q[g] | (32'd1 << (31 - g));
      end
    end
    always_ff @(posedge clk_i) begin
      rem_q[g+1]  <= rem_d;
      root_q[g+1] <= root_d;
    end
  end

  assign root_o = root_q[Steps];

endmodule

// ----- src/equirect_to_cubemap_remap_unit.sv -----
// Top level of the equirectangular to cubemap remap unit.
//
// Usage: raise start_i with out_col_i/out_row_i for one cycle per pixel; busy_o
// is always low, so a new pixel is taken in every cycle. Each result appears
// for exactly one cycle with done_o high, in input order, and the receiver
// cannot stall it. The pipeline runs through face decode and vector build,
// squares, a 33 stage square root, a 21 stage CORDIC for latitude, and the
// quantize, scaling multiply and output stages. The longitude CORDIC runs
// alongside and is delayed to match. Throughput is one pixel per clock.
// The user must write the configuration port (cfg_we_i, cfg_idx_i,
// cfg_wdata_i) only while no pixels are in flight; the block does not
// enforce this. Reset clears every valid bit and loads the register
// defaults of 1024, 4096 and 2048; no clearing pass is needed.
module equirect_to_cubemap_remap_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [12:0] out_col_i,
  input  logic [11:0] out_row_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [12:0] cfg_wdata_i,
  output logic        done_o,
  output logic [2:0]  face_o,
  output logic [10:0] face_x_o,
  output logic [10:0] face_y_o,
  output logic [12:0] src_col_o,
  output logic [11:0] src_row_o,
  output logic        outside_o
);

  localparam int unsigned VW = e2c_pkg::VecW;
  localparam int unsigned AB = e2c_pkg::AngleBits;
  // Delay of the latitude path from the registered vector to its angle.
  localparam int unsigned SqrtLat = 1 + 33;
  localparam int unsigned CordLat = e2c_pkg::Iters + 1;
  localparam int unsigned MidLat  = SqrtLat + CordLat;

  assign busy_o = 1'b0;

  // Configuration registers.
  logic [11:0] face_size_q;
  logic [12:0] pano_width_q;
  logic [12:0] pano_height_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      face_size_q   <= 12'd1024;
      pano_width_q  <= 13'd4096;
      pano_height_q <= 13'd2048;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        e2c_pkg::CfgFaceSize:   face_size_q   <= cfg_wdata_i[11:0];
        e2c_pkg::CfgPanoWidth:  pano_width_q  <= cfg_wdata_i;
        e2c_pkg::CfgPanoHeight: pano_height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // The face size is used saturated at the largest supported face.
  logic [11:0] su;
  assign su = (face_size_q > 12'(e2c_pkg::MaxFaceSize)) ? 12'(e2c_pkg::MaxFaceSize)
                                                         : face_size_q;

  // Stage 1: compare against the face borders.
  logic [13:0] s1, s2, s3;
  assign s1 = {2'b0, su};
  assign s2 = {1'b0, su, 1'b0};
  assign s3 = s1 + s2;

  logic        v1_q;
  logic        out1_q;
  logic [1:0]  k1_q;
  logic        bot1_q;
  logic [12:0] c1_q;
  logic [11:0] r1_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else         v1_q <= start_i;
  end
  always_ff @(posedge clk_i) begin
    out1_q <= ({1'b0, out_col_i} >= s3) || ({2'b0, out_row_i} >= s2);
    k1_q   <= ({1'b0, out_col_i} < s1) ? 2'd0 : (({1'b0, out_col_i} < s2) ? 2'd1 : 2'd2);
    bot1_q <= {2'b0, out_row_i} >= s1;
    c1_q   <= out_col_i;
    r1_q   <= out_row_i;
  end

  // Stage 2: local position, face and doubled vector.
  logic [12:0] tx, ty;
  logic signed [13:0] ss, u, w, x2, y2, z2;
  logic [2:0] fc;
  always_comb begin
    unique case (k1_q)
      2'd0:    tx = c1_q;
      2'd1:    tx = c1_q - {1'b0, su};
      default: tx = c1_q - {su, 1'b0};
    endcase
    ty = bot1_q ? 13'(r1_q) - {1'b0, su} : 13'(r1_q);
    ss = $signed(s1);
    u  = $signed({tx, 1'b0}) - ss;
    w  = $signed({ty, 1'b0}) - ss;
    fc = bot1_q ? 3'(k1_q) + 3'd3 : 3'(k1_q);
    unique case (fc)
      e2c_pkg::FaceYp: begin x2 = u;   y2 = ss;  z2 = w;  end
      e2c_pkg::FaceXp: begin x2 = ss;  y2 = -u;  z2 = w;  end
      e2c_pkg::FaceYm: begin x2 = -u;  y2 = -ss; z2 = w;  end
      e2c_pkg::FaceXm: begin
        // Halve toward zero, then double again.
        x2 = -$signed({s1[13:1], 1'b0});
        y2 = (u[13] ? -((-u) >>> 1) : (u >>> 1)) <<< 1;
        z2 = (w[13] ? -((-w) >>> 1) : (w >>> 1)) <<< 1;
      end
      e2c_pkg::FaceZm: begin x2 = -w;  y2 = -u;  z2 = ss; end
      default:         begin x2 = w;   y2 = -u;  z2 = -ss; end
    endcase
  end

  logic                v2_q;
  e2c_pkg::side_t      sd2_q;
  logic signed [VW-1:0] xs2_q, ys2_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else         v2_q <= v1_q;
  end
  always_ff @(posedge clk_i) begin
    sd2_q.outside  <= out1_q;
    sd2_q.face     <= fc;
    sd2_q.face_x   <= tx[10:0];
    sd2_q.face_y   <= ty[10:0];
    sd2_q.lon_zero <= (x2 == 14'sd0) && (y2 == 14'sd0);
    sd2_q.z        <= z2;
    xs2_q <= VW'(x2) <<< 16;
    ys2_q <= VW'(y2) <<< 16;
  end

  // Stage 3: squares of the scaled components; the 2^32 factor is a shift.
  logic signed [27:0] xw3, yw3;
  assign xw3 = 28'($signed(xs2_q[VW-1:16]));
  assign yw3 = 28'($signed(ys2_q[VW-1:16]));
  logic [27:0] xsq3_q, ysq3_q;
  always_ff @(posedge clk_i) begin
    xsq3_q <= xw3 * xw3;
    ysq3_q <= yw3 * yw3;
  end
  logic [63:0] hsq3;
  assign hsq3 = {7'd0, 29'({1'b0, xsq3_q} + {1'b0, ysq3_q}), 28'd0} << 4;

  logic [31:0] h_root;
  e2c_isqrt u_sqrt (
    .clk_i (clk_i),
    .n_i   (hsq3),
    .root_o(h_root)
  );

  // Side data and the longitude vector are delayed across the square root.
  e2c_pkg::side_t sd_q [SqrtLat];
  logic signed [VW-1:0] xl_q [SqrtLat];
  logic signed [VW-1:0] yl_q [SqrtLat];
  logic [SqrtLat-1:0]   vd_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vd_q <= '0;
    else         vd_q <= {vd_q[SqrtLat-2:0], v2_q};
  end
  always_ff @(posedge clk_i) begin
    sd_q[0] <= sd2_q;
    xl_q[0] <= xs2_q;
    yl_q[0] <= ys2_q;
    for (int i = 1; i < SqrtLat; i++) begin
      sd_q[i] <= sd_q[i-1];
      xl_q[i] <= xl_q[i-1];
      yl_q[i] <= yl_q[i-1];
    end
  end

  e2c_pkg::side_t sdm;
  logic signed [VW-1:0] lat_x, lat_y;
  assign sdm   = sd_q[SqrtLat-1];
  assign lat_y = VW'({1'b0, h_root});
  assign lat_x = -(VW'(sdm.z) <<< 16);

  logic        lat_v, lon_v;
  logic [31:0] lat_a, lon_a;
  e2c_cordic u_lat (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .valid_i(vd_q[SqrtLat-1]),
    .x_i   (lat_x),
    .y_i   (lat_y),
    .valid_o(lat_v),
    .angle_o(lat_a)
  );
  e2c_cordic u_lon (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .valid_i(vd_q[SqrtLat-1]),
    .x_i   (xl_q[SqrtLat-1]),
    .y_i   (yl_q[SqrtLat-1]),
    .valid_o(lon_v),
    .angle_o(lon_a)
  );

  // Side data and pole flag across the CORDIC.
  e2c_pkg::side_t sc_q [CordLat];
  logic [CordLat-1:0] hz_q;
  always_ff @(posedge clk_i) begin
    sc_q[0] <= sdm;
    hz_q[0] <= (h_root == 32'd0);
    for (int i = 1; i < CordLat; i++) begin
      sc_q[i] <= sc_q[i-1];
      hz_q[i] <= hz_q[i-1];
    end
  end

  // Angle clean-up and quantization.
  e2c_pkg::side_t sc;
  logic [31:0] t_ang, p_ang;
  assign sc = sc_q[CordLat-1];
  always_comb begin
    t_ang = sc.lon_zero ? 32'd0 : (32'd0 - lon_a);
    if (hz_q[CordLat-1]) begin
      p_ang = (sc.z > 14'sd0) ? 32'h8000_0000 : 32'd0;
    end else if (lat_a >= 32'hC000_0000) begin
      p_ang = 32'd0;
    end else if (lat_a > 32'h8000_0000) begin
      p_ang = 32'h8000_0000;
    end else begin
      p_ang = lat_a;
    end
  end

  logic           v4_q;
  e2c_pkg::side_t sd4_q;
  logic [AB-1:0]  tq4_q;
  logic [AB:0]    pq4_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else         v4_q <= lat_v & lon_v;
  end
  always_ff @(posedge clk_i) begin
    sd4_q <= sc;
    tq4_q <= t_ang[31 -: AB];
    pq4_q <= {1'b0, p_ang[31 -: AB]};
  end

  // Scaling multiplies.
  logic           v5_q;
  e2c_pkg::side_t sd5_q;
  logic [12:0]    col5_q;
  logic [13:0]    row5_q;
  logic [AB+12:0] colp;
  logic [AB+12:0] rowp;
  assign colp = (AB + 13)'(tq4_q) * (AB + 13)'(pano_width_q);
  assign rowp = (AB + 13)'(pq4_q) * (AB + 13)'(pano_height_q);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v5_q <= 1'b0;
    else         v5_q <= v4_q;
  end
  always_ff @(posedge clk_i) begin
    sd5_q  <= sd4_q;
    col5_q <= colp[AB+12:AB];
    row5_q <= rowp[AB+12:AB-1];
  end

  // Wrap and output register.
  logic [12:0] colw;
  logic [13:0] roww;
  assign colw = (col5_q >= pano_width_q) ? col5_q - pano_width_q : col5_q;
  assign roww = (row5_q >= {1'b0, pano_height_q}) ? row5_q - {1'b0, pano_height_q} : row5_q;

  logic v6_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v6_q <= 1'b0;
    else         v6_q <= v5_q;
  end
  always_ff @(posedge clk_i) begin
    outside_o <= sd5_q.outside;
    face_o    <= sd5_q.outside ? 3'd0  : sd5_q.face;
    face_x_o  <= sd5_q.outside ? 11'd0 : sd5_q.face_x;
    face_y_o  <= sd5_q.outside ? 11'd0 : sd5_q.face_y;
    src_col_o <= sd5_q.outside ? 13'd0 : colw;
    src_row_o <= sd5_q.outside ? 12'd0 : roww[11:0];
  end
  assign done_o = v6_q;

endmodule
